/* design/bums_pkg.sv */
// ----------------------------------------------------------------------------
// bums_pkg
// shared types and constants of the merge sorter: request and result payloads,
// cell control bundle and default sizes
// ----------------------------------------------------------------------------
package bums_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_req;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } t_res;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

/* design/bums_cell.sv */
// ----------------------------------------------------------------------------
// bums_cell
// one slot of the sorting chain: holds one value, makes room for a smaller
// incoming key by taking its left neighbor, and shifts left during drain
// ----------------------------------------------------------------------------
module bums_cell #(
    parameter int DATA_WIDTH = bums_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bums_pkg::t_cell_ctl          i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_key,
    input  logic                         i_left_lt,
    input  logic signed [DATA_WIDTH-1:0] i_left_value,
    input  logic                         i_left_valid,
    input  logic signed [DATA_WIDTH-1:0] i_right_value,
    input  logic                         i_right_valid,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_valid,
    output logic                         o_lt
);

    logic signed [DATA_WIDTH-1:0] r_value;
    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic                         n_valid;

    assign o_lt = !r_valid || (i_key < r_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.load && o_lt) begin
            if (i_left_lt) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_key;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

/* design/bottom_up_merge_sorter_top.sv */
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter_top
// loads a data set and returns it in ascending order with the last value
// marked
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, one per cycle while
// loading; each value is placed into its sorted slot of a chain of CAPACITY
// cells as it arrives. Requests past CAPACITY are dropped and flag overflow on
// every result of that data set. The request marked last starts the drain:
// the chain shifts one slot per cycle, giving one result per stored value on
// o_strobe. Busy is high during the drain. Results cannot be held off and
// must be captured in the cycle o_strobe is high.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter_top #(
    parameter int CAPACITY   = bums_pkg::CAPACITY,
    parameter int DATA_WIDTH = bums_pkg::DATA_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bums_pkg::t_req i_req,
    output logic           busy,
    output logic           o_strobe,
    output bums_pkg::t_res o_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic          r_dropped, n_dropped;

    logic                         w_accept;
    logic                         w_room;
    logic [63:0]                  w_raw;
    logic signed [DATA_WIDTH-1:0] w_key;
    logic [63:0]                  w_out;
    bums_pkg::t_cell_ctl          w_ctl;

    logic signed [DATA_WIDTH-1:0] w_value [CAPACITY];
    logic                         w_valid [CAPACITY];
    logic                         w_lt    [CAPACITY];

    assign busy     = (r_state == ST_DRAIN);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < CW'(CAPACITY));
    assign w_raw    = {32'b0, i_req.value};
    assign w_key    = w_raw[DATA_WIDTH-1:0];

    assign w_ctl.load  = w_accept && w_room;
    assign w_ctl.shift = busy;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                         w_left_lt;
        logic signed [DATA_WIDTH-1:0] w_left_value;
        logic                         w_left_valid;
        logic signed [DATA_WIDTH-1:0] w_right_value;
        logic                         w_right_valid;

        if (i == 0) begin : g_first
            assign w_left_lt    = 1'b0;
            assign w_left_value = '0;
            assign w_left_valid = 1'b0;
        end else begin : g_inner
            assign w_left_lt    = w_lt[i-1];
            assign w_left_value = w_value[i-1];
            assign w_left_valid = w_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_value = w_value[i+1];
            assign w_right_valid = w_valid[i+1];
        end

        bums_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_key),
            .i_left_lt    (w_left_lt),
            .i_left_value (w_left_value),
            .i_left_valid (w_left_valid),
            .i_right_value(w_right_value),
            .i_right_valid(w_right_valid),
            .o_value      (w_value[i]),
            .o_valid      (w_valid[i]),
            .o_lt         (w_lt[i])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_req.last) begin
                        n_state = ST_DRAIN;
                        n_left  = w_room ? (r_count + CW'(1)) : r_count;
                    end
                end
            end
            ST_DRAIN: begin
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state   = ST_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_left    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_dropped <= n_dropped;
        end
    end

    assign w_out              = 64'(w_value[0]);
    assign o_strobe           = busy;
    assign o_res.sorted_value = w_out[31:0];
    assign o_res.final_res    = (r_left == CW'(1));
    assign o_res.overflow     = r_dropped;

    a_final_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.final_res |=> !busy)
        else $error("drain did not end after final result");

    a_drain_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.final_res |=> o_strobe)
        else $error("drain stopped before final result");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> w_valid[0])
        else $error("result taken from an empty slot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("item count beyond capacity");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the bottom-up merge sorter: directed data sets
// (extremes, equal values, descending order) followed by random data sets,
// including one that fills capacity and overruns it; the single-value sets are
// checked against the expected value in their row and every other result
// against an in-bench sorter model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_TAIL  = 2 * bums_pkg::CAPACITY + 8;
    localparam int N_ROWS      = 15;
    localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic signed [31:0] want;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    bums_pkg::t_req i_req;
    logic           busy;
    logic           o_strobe;
    bums_pkg::t_res o_res;

    bums_pkg::t_res     sorted_queue[$];
    bums_pkg::t_res     new_results[$];
    logic signed [31:0] held_values[$];
    bit                 dropped;
    int                 idle_pct;
    int                 errors;
    int                 results_seen;
    int                 items_sent;
    int                 sets_done;
    int                 overflow_sets;
    int                 cycles;
    t_row               directed_rows[N_ROWS];

    bottom_up_merge_sorter_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bottom_up_merge_sorter_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        bums_pkg::t_res want_res;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (sorted_queue.size() == 0) begin
                errors++;
                $error("unexpected result: sorted_value %0d", o_res.sorted_value);
            end else begin
                want_res = sorted_queue.pop_front();
                if (o_res.sorted_value !== want_res.sorted_value) begin
                    errors++;
                    $error("sorted_value: expected %0d, got %0d",
                           want_res.sorted_value, o_res.sorted_value);
                end
                if (o_res.final_res !== want_res.final_res) begin
                    errors++;
                    $error("final_res: expected %0b, got %0b",
                           want_res.final_res, o_res.final_res);
                end
                if (o_res.overflow !== want_res.overflow) begin
                    errors++;
                    $error("overflow: expected %0b, got %0b",
                           want_res.overflow, o_res.overflow);
                end
            end
        end
    end

    // model of the sorter: collect values up to capacity, sort ascending on the last request
    task automatic sort_on_request(input bums_pkg::t_req req);
        logic signed [31:0] ordered[$];
        logic signed [31:0] v;
        bums_pkg::t_res     r;
        int                 j;
        new_results = {};
        if (held_values.size() < bums_pkg::CAPACITY)
            held_values.push_back(req.value);
        else
            dropped = 1'b1;
        if (req.last) begin
            ordered = held_values;
            for (int i = 1; i < ordered.size(); i++) begin
                v = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > v) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = v;
            end
            for (int k = 0; k < ordered.size(); k++) begin
                r.sorted_value = ordered[k];
                r.final_res    = (k == ordered.size() - 1);
                r.overflow     = dropped;
                new_results.push_back(r);
            end
            if (dropped)
                overflow_sets++;
            sets_done++;
            held_values = {};
            dropped     = 1'b0;
        end
    endtask

    task automatic send_request(input bums_pkg::t_req req, input bit typed,
                                input logic signed [31:0] want);
        bums_pkg::t_res r;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sort_on_request(req);
        items_sent++;
        if (typed) begin
            r.sorted_value = want;
            r.final_res    = 1'b1;
            r.overflow     = 1'b0;
            sorted_queue.push_back(r);
        end else begin
            foreach (new_results[k])
                sorted_queue.push_back(new_results[k]);
        end
    endtask

    task automatic go_quiet_and_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sorted_queue.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return MIN_VAL;
            1:       return MAX_VAL;
            2, 3:    return $signed($urandom_range(4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int             n_set;
        int             set_idx;
        int             random_items;
        bums_pkg::t_req req;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        cycles        = 0;
        errors        = 0;
        results_seen  = 0;
        items_sent    = 0;
        sets_done     = 0;
        overflow_sets = 0;
        idle_pct      = 0;
        dropped       = 1'b0;

        // single-value sets
        directed_rows[0]  = '{MIN_VAL, 1'b1, 1'b1, MIN_VAL};
        directed_rows[1]  = '{MAX_VAL, 1'b1, 1'b1, MAX_VAL};
        directed_rows[2]  = '{32'sd0,  1'b1, 1'b1, 32'sd0};
        directed_rows[3]  = '{-32'sd1, 1'b1, 1'b1, -32'sd1};
        // mixed set with equal values
        directed_rows[4]  = '{32'sd5,  1'b0, 1'b0, 32'sd0};
        directed_rows[5]  = '{-32'sd3, 1'b0, 1'b0, 32'sd0};
        directed_rows[6]  = '{32'sd5,  1'b0, 1'b0, 32'sd0};
        directed_rows[7]  = '{MAX_VAL, 1'b0, 1'b0, 32'sd0};
        directed_rows[8]  = '{MIN_VAL, 1'b0, 1'b0, 32'sd0};
        directed_rows[9]  = '{32'sd0,  1'b0, 1'b0, 32'sd0};
        directed_rows[10] = '{-32'sd1, 1'b1, 1'b0, 32'sd0};
        // descending set
        directed_rows[11] = '{32'sd3,  1'b0, 1'b0, 32'sd0};
        directed_rows[12] = '{32'sd2,  1'b0, 1'b0, 32'sd0};
        directed_rows[13] = '{32'sd1,  1'b0, 1'b0, 32'sd0};
        directed_rows[14] = '{32'sd0,  1'b1, 1'b0, 32'sd0};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            req.value = directed_rows[r].value;
            req.last  = directed_rows[r].last;
            send_request(req, directed_rows[r].typed, directed_rows[r].want);
        end
        go_quiet_and_drain();

        // random sets, one overrunning capacity
        set_idx      = 0;
        random_items = 0;
        while (random_items < 85 || set_idx < 4) begin
            case (set_idx % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 48;
                2:       idle_pct = 0;
                default: idle_pct = 6;
            endcase
            if (set_idx == 2)
                n_set = bums_pkg::CAPACITY + $urandom_range(1, 3);
            else
                n_set = $urandom_range(1, 12);
            for (int k = 0; k < n_set; k++) begin
                req.value = pick_value();
                req.last  = (k == n_set - 1);
                send_request(req, 1'b0, '0);
                random_items++;
            end
            if (set_idx == 3)
                go_quiet_and_drain();
            set_idx++;
        end

        go_quiet_and_drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("%0d requests in %0d data sets (%0d overrun capacity), %0d results checked",
                 items_sent, sets_done, overflow_sets, results_seen);
        if (errors == 0) begin
            $display("bottom_up_merge_sorter_top regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("bottom_up_merge_sorter_top regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
design/bums_pkg.sv
design/bums_cell.sv
design/bottom_up_merge_sorter_top.sv
sim/testbench.sv
